// File: src/tmr_pkg.sv
package tmr_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TIME_W   = 64;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        channel;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] interval;
        logic              repeat_req;
    } t_in_word;

    typedef struct packed {
        logic [2:0] fired_channel;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] period;
    } t_entry;

    typedef struct packed {
        logic            we;
        logic [CH_W-1:0] waddr;
        t_entry          wdata;
        logic            re;
        logic [CH_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_push;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage

// File: src/tmr_ram.sv
module tmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/tmr_out.sv
module tmr_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tmr_pkg::t_push    i_push,
    output logic              o_free,
    output logic              o_out_valid,
    output tmr_pkg::t_out_word o_out,
    input  logic              i_out_stall
);

    logic               r_vld;
    tmr_pkg::t_out_word r_word;

    assign o_free = !r_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push.valid) begin
            r_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_word <= i_push.word;
        end
    end

    assign o_out_valid = r_vld;
    assign o_out       = r_word;

endmodule

// File: src/tmr_ctrl.sv
module tmr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  tmr_pkg::t_in_word     i_in,
    output logic                  o_in_stall,
    input  tmr_pkg::t_entry       i_rd_data,
    output tmr_pkg::t_ram_req     o_ram,
    output tmr_pkg::t_push        o_push,
    input  logic                  i_out_free
);

    tmr_pkg::t_state r_state, n_state;
    logic [tmr_pkg::CHANNELS-1:0] r_armed, n_armed;
    logic [tmr_pkg::CHANNELS-1:0] r_periodic, n_periodic;
    logic [tmr_pkg::CH_W-1:0]     r_idx, n_idx;
    logic [tmr_pkg::CH_W-1:0]     r_pend_ch, n_pend_ch;
    logic                         r_pend_vld, n_pend_vld;
    logic [tmr_pkg::TIME_W-1:0]   r_now, n_now;

    logic                         fire;
    logic                         step;
    logic                         ch_ok;
    logic [tmr_pkg::CH_W-1:0]     ch_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tmr_pkg::ST_IDLE;
            r_armed    <= '0;
            r_periodic <= '0;
            r_pend_vld <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_armed    <= n_armed;
            r_periodic <= n_periodic;
            r_pend_vld <= n_pend_vld;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_ch <= n_pend_ch;
        r_now     <= n_now;
    end

    assign ch_idx = tmr_pkg::CH_W'(i_in.channel);
    assign ch_ok  = 32'(i_in.channel) < tmr_pkg::CHANNELS;
    // read data belongs to r_idx while scanning
    assign fire   = r_armed[r_idx] && (i_rd_data.deadline < r_now);
    // a second firing needs the held one pushed out first
    assign step   = !fire || !r_pend_vld || i_out_free;

    always_comb begin
        n_state    = r_state;
        n_armed    = r_armed;
        n_periodic = r_periodic;
        n_idx      = r_idx;
        n_pend_ch  = r_pend_ch;
        n_pend_vld = r_pend_vld;
        n_now      = r_now;
        o_in_stall = 1'b1;
        o_ram      = '0;
        o_push     = '0;

        unique case (r_state)
            tmr_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    unique case (i_in.kind)
                        tmr_pkg::KIND_TICK: begin
                            o_ram.re    = 1'b1;
                            o_ram.raddr = '0;
                            n_idx       = '0;
                            n_now       = i_in.now;
                            n_state     = tmr_pkg::ST_SCAN;
                        end
                        tmr_pkg::KIND_START: begin
                            if (ch_ok) begin
                                o_ram.we             = 1'b1;
                                o_ram.waddr          = ch_idx;
                                o_ram.wdata.deadline = i_in.now + i_in.interval;
                                o_ram.wdata.period   = i_in.interval;
                                n_armed[ch_idx]      = 1'b1;
                                n_periodic[ch_idx]   = i_in.repeat_req;
                            end
                        end
                        tmr_pkg::KIND_STOP: begin
                            if (ch_ok) begin
                                n_armed[ch_idx] = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tmr_pkg::ST_SCAN: begin
                if (step) begin
                    if (fire) begin
                        if (r_periodic[r_idx]) begin
                            o_ram.we             = 1'b1;
                            o_ram.waddr          = r_idx;
                            o_ram.wdata.deadline = i_rd_data.deadline + i_rd_data.period;
                            o_ram.wdata.period   = i_rd_data.period;
                        end else begin
                            n_armed[r_idx] = 1'b0;
                        end
                        if (r_pend_vld) begin
                            o_push.valid              = 1'b1;
                            o_push.word.fired_channel = 3'(r_pend_ch);
                            o_push.word.last          = 1'b0;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_ch  = r_idx;
                    end
                    if (r_idx == tmr_pkg::CH_W'(tmr_pkg::CHANNELS - 1)) begin
                        n_state = tmr_pkg::ST_FLUSH;
                    end else begin
                        n_idx       = r_idx + 1'b1;
                        o_ram.re    = 1'b1;
                        o_ram.raddr = r_idx + 1'b1;
                    end
                end
            end
            tmr_pkg::ST_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = tmr_pkg::ST_IDLE;
                end else if (i_out_free) begin
                    o_push.valid              = 1'b1;
                    o_push.word.fired_channel = 3'(r_pend_ch);
                    o_push.word.last          = 1'b1;
                    n_pend_vld                = 1'b0;
                    n_state                   = tmr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tmr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/multi_channel_soft_timer.sv
// Bank of CHANNELS one-shot/periodic timers. A tick word is accepted in
// the idle state; the scan then reads each channel's deadline and period
// from the channel memory in turn (one read and at most one write-back per
// cycle unless a stalled output holds the scan), and the flush state
// releases the final expiry word, if any, with last set. Expiry words
// come out in channel order, one per fired channel.
module multi_channel_soft_timer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  tmr_pkg::t_in_word  i_in,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output tmr_pkg::t_out_word o_out,
    input  logic               i_out_stall
);

    tmr_pkg::t_ram_req ram_req;
    tmr_pkg::t_entry   rd_data;
    tmr_pkg::t_push    push;
    logic              out_free;

    tmr_ram #(
        .WIDTH ($bits(tmr_pkg::t_entry)),
        .DEPTH (tmr_pkg::CHANNELS),
        .AW    (tmr_pkg::CH_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    tmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_rd_data  (rd_data),
        .o_ram      (ram_req),
        .o_push     (push),
        .i_out_free (out_free)
    );

    tmr_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: src/tmr_checker.sv
module tmr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input tmr_pkg::t_in_word  i_in,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input tmr_pkg::t_out_word o_out,
    input logic               i_out_stall
);

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output word changed");

    a_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out.fired_channel) < tmr_pkg::CHANNELS)
        else $error("fired channel out of range");

    // start/stop never produce an expiry word
    a_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.kind != tmr_pkg::KIND_TICK
        && !(o_out_valid && i_out_stall) |=> !o_out_valid)
        else $error("expiry word after start or stop");

    // a tick keeps the block busy while it scans
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.kind == tmr_pkg::KIND_TICK |=> o_in_stall)
        else $error("input taken during scan");

endmodule

bind multi_channel_soft_timer tmr_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in        (i_in),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out       (o_out),
    .i_out_stall (i_out_stall)
);
